// File: design/boxiou_pkg.sv
// ----------------------------------------------------------------------------
// boxiou_pkg
// Shared widths, constants and stage types for the box intersection over
// union pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package boxiou_pkg;

  // coordinate and ratio formats
  localparam int COORD_BITS      = 16;
  localparam int AREA_W          = 2 * COORD_BITS;
  localparam int UNION_W         = AREA_W + 1;
  localparam int RATIO_FRAC_BITS = 16;
  localparam int RATIO_W         = RATIO_FRAC_BITS + 1;
  localparam int DIV_STEPS       = RATIO_FRAC_BITS;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [AREA_W-1:0]     area_t;
  typedef logic [UNION_W-1:0]    union_t;
  typedef logic [RATIO_W-1:0]    ratio_t;

  // intersection spans and box sizes after the edge stage
  typedef struct packed {
    logic   ovl;
    coord_t iw;
    coord_t ih;
    coord_t aw;
    coord_t ah;
    coord_t bw;
    coord_t bh;
  } geom_t;

  // numerator and denominator after the area stages
  typedef struct packed {
    logic   ovl;
    area_t  inter;
    union_t uni;
  } frac_t;

  // one step of the restoring divider
  typedef struct packed {
    logic                       ovl;
    logic                       full;
    union_t                     rem;
    union_t                     den;
    logic [RATIO_FRAC_BITS-1:0] q;
  } div_t;

endpackage

`default_nettype wire

// File: design/boxiou_geom.sv
// ----------------------------------------------------------------------------
// boxiou_geom
// Edge stage: right and bottom edges, intersection spans and overlap test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boxiou_geom (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  boxiou_pkg::coord_t  box_a_left,
  input  boxiou_pkg::coord_t  box_a_top,
  input  boxiou_pkg::coord_t  box_a_width,
  input  boxiou_pkg::coord_t  box_a_height,
  input  boxiou_pkg::coord_t  box_b_left,
  input  boxiou_pkg::coord_t  box_b_top,
  input  boxiou_pkg::coord_t  box_b_width,
  input  boxiou_pkg::coord_t  box_b_height,
  output logic                out_valid,
  output boxiou_pkg::geom_t   geom
);
  import boxiou_pkg::*;

  logic [COORD_BITS:0] a_right, a_bottom, b_right, b_bottom;
  logic [COORD_BITS:0] right, bottom, left_ext, top_ext, iw_full, ih_full;
  coord_t              left, top;
  geom_t               geom_next;

  // far edges carry one extra bit
  always_comb begin
    a_right  = {1'b0, box_a_left} + {1'b0, box_a_width};
    a_bottom = {1'b0, box_a_top}  + {1'b0, box_a_height};
    b_right  = {1'b0, box_b_left} + {1'b0, box_b_width};
    b_bottom = {1'b0, box_b_top}  + {1'b0, box_b_height};
    left     = (box_a_left > box_b_left) ? box_a_left : box_b_left;
    top      = (box_a_top > box_b_top) ? box_a_top : box_b_top;
    right    = (a_right < b_right) ? a_right : b_right;
    bottom   = (a_bottom < b_bottom) ? a_bottom : b_bottom;
    left_ext = {1'b0, left};
    top_ext  = {1'b0, top};
    iw_full  = right - left_ext;
    ih_full  = bottom - top_ext;

    // a positive span is never wider than the narrower box
    geom_next.ovl = (left_ext < right) && (top_ext < bottom);
    geom_next.iw  = iw_full[COORD_BITS-1:0];
    geom_next.ih  = ih_full[COORD_BITS-1:0];
    geom_next.aw  = box_a_width;
    geom_next.ah  = box_a_height;
    geom_next.bw  = box_b_width;
    geom_next.bh  = box_b_height;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geom <= geom_next;
    end
  end

endmodule

`default_nettype wire

// File: design/boxiou_area.sv
// ----------------------------------------------------------------------------
// boxiou_area
// Two stages: intersection and box areas, then the union area.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boxiou_area (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  boxiou_pkg::geom_t   geom,
  output logic                out_valid,
  output boxiou_pkg::frac_t   frac
);
  import boxiou_pkg::*;

  logic   prod_valid;
  logic   prod_ovl;
  area_t  inter, area_a, area_b;
  union_t uni_next;

  // products, one multiplier each
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_ovl <= geom.ovl;
      inter    <= AREA_W'(geom.iw) * AREA_W'(geom.ih);
      area_a   <= AREA_W'(geom.aw) * AREA_W'(geom.ah);
      area_b   <= AREA_W'(geom.bw) * AREA_W'(geom.bh);
    end
  end

  // union = area a + area b - intersection
  assign uni_next = {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac.ovl   <= prod_ovl;
      frac.inter <= inter;
      frac.uni   <= uni_next;
    end
  end

endmodule

`default_nettype wire

// File: design/boxiou_div.sv
// ----------------------------------------------------------------------------
// boxiou_div
// Pipelined restoring divider: one quotient bit per stage, Q1.16 result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boxiou_div (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 en,
  input  wire                 in_valid,
  input  boxiou_pkg::frac_t   frac,
  output logic                out_valid,
  output boxiou_pkg::ratio_t  ratio,
  output logic                ovl
);
  import boxiou_pkg::*;

  div_t                 src       [DIV_STEPS];
  div_t                 step_next [DIV_STEPS];
  div_t                 step      [DIV_STEPS];
  logic                 step_valid [DIV_STEPS];

  // entry: ratio of one when the intersection fills the union
  always_comb begin
    src[0].ovl  = frac.ovl;
    src[0].full = ({1'b0, frac.inter} >= frac.uni);
    src[0].rem  = {1'b0, frac.inter};
    src[0].den  = frac.uni;
    src[0].q    = '0;
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic [UNION_W:0] rem_sh, rem_sub;

    if (g > 0) begin : g_link
      assign src[g] = step[g-1];
    end

    // shift, trial subtract, keep or restore
    always_comb begin
      rem_sh       = {src[g].rem, 1'b0};
      rem_sub      = rem_sh - {1'b0, src[g].den};
      step_next[g] = src[g];
      if (rem_sh >= {1'b0, src[g].den}) begin
        step_next[g].rem = rem_sub[UNION_W-1:0];
        step_next[g].q   = {src[g].q[RATIO_FRAC_BITS-2:0], 1'b1};
      end else begin
        step_next[g].rem = rem_sh[UNION_W-1:0];
        step_next[g].q   = {src[g].q[RATIO_FRAC_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        step_valid[g] <= 1'b0;
      end else if (en) begin
        step_valid[g] <= (g == 0) ? in_valid : step_valid[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        step[g] <= step_next[g];
      end
    end
  end

  // result select after the last step
  assign out_valid = step_valid[DIV_STEPS-1];
  assign ovl       = step[DIV_STEPS-1].ovl;
  assign ratio     = !step[DIV_STEPS-1].ovl ? '0 :
                     step[DIV_STEPS-1].full ? RATIO_ONE :
                     {1'b0, step[DIV_STEPS-1].q};

endmodule

`default_nettype wire

// File: design/box_intersection_over_union_core.sv
// ----------------------------------------------------------------------------
// box_intersection_over_union_core
// Intersection over union of two axis-aligned boxes in Q0.16, result Q1.16.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, in order. The pipeline takes a new
// box pair every cycle unless held, and returns its ratio after passing one
// edge stage, two area stages (products, then union), sixteen divider stages
// that each settle one quotient bit, and the output register. The whole
// pipeline holds while a finished result waits on out_ready; a pair that does
// not overlap, or only touches, gives ratio 0 with boxes_overlap low.
`timescale 1ns / 1ps
`default_nettype none

module box_intersection_over_union_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  boxiou_pkg::coord_t  box_a_left,
  input  boxiou_pkg::coord_t  box_a_top,
  input  boxiou_pkg::coord_t  box_a_width,
  input  boxiou_pkg::coord_t  box_a_height,
  input  boxiou_pkg::coord_t  box_b_left,
  input  boxiou_pkg::coord_t  box_b_top,
  input  boxiou_pkg::coord_t  box_b_width,
  input  boxiou_pkg::coord_t  box_b_height,
  output logic                out_valid,
  input  wire                 out_ready,
  output boxiou_pkg::ratio_t  overlap_ratio,
  output logic                boxes_overlap
);
  import boxiou_pkg::*;

  logic   en;
  logic   geom_valid, frac_valid, div_valid, div_ovl;
  geom_t  geom;
  frac_t  frac;
  ratio_t div_ratio;

  // pipeline moves whenever the output register is free or being drained
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  boxiou_geom u_geom (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .box_a_left   (box_a_left),
    .box_a_top    (box_a_top),
    .box_a_width  (box_a_width),
    .box_a_height (box_a_height),
    .box_b_left   (box_b_left),
    .box_b_top    (box_b_top),
    .box_b_width  (box_b_width),
    .box_b_height (box_b_height),
    .out_valid    (geom_valid),
    .geom         (geom)
  );

  boxiou_area u_area (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geom_valid),
    .geom      (geom),
    .out_valid (frac_valid),
    .frac      (frac)
  );

  boxiou_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (frac_valid),
    .frac      (frac),
    .out_valid (div_valid),
    .ratio     (div_ratio),
    .ovl       (div_ovl)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap_ratio <= div_ratio;
      boxes_overlap <= div_ovl;
    end
  end

endmodule

`default_nettype wire
